// ===== sv/quad_motor_mixer_sqrt_core_macros.svh =====
// Assertion macros shared by the motor mixer RTL.
`ifndef QUAD_MOTOR_MIXER_SQRT_CORE_MACROS_SVH
`define QUAD_MOTOR_MIXER_SQRT_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QMM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("motor mixer check failed");

// The consequent must hold in the cycle after the antecedent.
`define QMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("motor mixer check failed");

`endif

// ===== sv/qmm_pkg.sv =====
// Types, constants and arithmetic helpers of the motor mixer.
package qmm_pkg;

	localparam int CMD_W     = 16;
	localparam int SPD_W     = 14;
	localparam int GAIN_W    = 6;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int LANES     = 4;
	localparam int SQ_W      = 17;
	localparam int ROOT_W    = 8;
	localparam int SQ_STEPS  = 8;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_LIFT_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOTOR_GAIN     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MOTOR_FLOOR    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MOTOR_CEILING  = 2'd3;

	// Register values after reset.
	localparam logic [CMD_W-1:0]  RST_LIFT_THRESHOLD = 16'd277;
	localparam logic [GAIN_W-1:0] RST_MOTOR_GAIN     = 6'd13;
	localparam logic [SPD_W-1:0]  RST_MOTOR_FLOOR    = 14'd200;
	localparam logic [SPD_W-1:0]  RST_MOTOR_CEILING  = 14'd600;

	// Largest possible root, the root of 32768.
	localparam logic [SQ_W-1:0] ROOT_MAX = 17'd181;

	// Trial bit of each square root step, from the top pair of bits down.
	localparam logic [SQ_W-1:0] SQRT_BIT [SQ_STEPS] = '{
		17'h4000, 17'h1000, 17'h0400, 17'h0100,
		17'h0040, 17'h0010, 17'h0004, 17'h0001
	};

	typedef struct packed {
		logic [SQ_W-1:0] rem;
		logic [SQ_W-1:0] root;
	} sqrt_t;

	// Magnitude of a 16-bit two's complement word, 0 to 32768.
	function automatic logic [SQ_W-1:0] mag16(input logic [CMD_W-1:0] v);
		logic [SQ_W-1:0] ext;
		ext = {1'b0, v};
		if (v[CMD_W-1]) begin
			return 17'h10000 - ext;
		end
		return ext;
	endfunction

	// One restoring step of the bitwise square root.
	function automatic sqrt_t sqrt_step(input sqrt_t st, input logic [SQ_W-1:0] bit_v);
		logic [SQ_W-1:0] trial;
		sqrt_t nx;
		trial   = st.root + bit_v;
		nx.root = st.root >> 1;
		nx.rem  = st.rem;
		if (trial <= st.rem) begin
			nx.root = nx.root + bit_v;
			nx.rem  = st.rem - trial;
		end
		return nx;
	endfunction

endpackage

// ===== sv/qmm_if.sv =====
// Valid/ready channels of the motor mixer: command words in, speed words out.
interface qmm_cmd_if;
	import qmm_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [CMD_W-1:0] lift_cmd;
	logic signed [CMD_W-1:0] roll_cmd;
	logic signed [CMD_W-1:0] pitch_cmd;
	logic signed [CMD_W-1:0] yaw_cmd;

	modport source (output valid, lift_cmd, roll_cmd, pitch_cmd, yaw_cmd, input ready);
	modport sink (input valid, lift_cmd, roll_cmd, pitch_cmd, yaw_cmd, output ready);
endinterface

interface qmm_spd_if;
	import qmm_pkg::*;
	logic             valid;
	logic             ready;
	logic [SPD_W-1:0] motor_front;
	logic [SPD_W-1:0] motor_right;
	logic [SPD_W-1:0] motor_back;
	logic [SPD_W-1:0] motor_left;

	modport source (output valid, motor_front, motor_right, motor_back, motor_left,
		input ready);
	modport sink (input valid, motor_front, motor_right, motor_back, motor_left,
		output ready);
endinterface

// ===== sv/quad_motor_mixer_sqrt_core.sv =====
// Quadcopter motor mixer: command word in, four motor speeds out through a
// seven-stage pipeline.
//
// The cmd channel takes one command word (lift, roll, pitch, yaw, signed) at
// each clock edge where valid and ready are high. The spd channel gives one
// word of four motor speeds per command, in command order. Configuration is
// written through cfg_we/cfg_index/cfg_data; the user must write it only while the pipeline is empty (not enforced).
//
// Stage 1 forms the four mixed terms and their magnitudes and compares lift
// with the threshold. Stages 2 to 5 each run two steps of the bitwise square
// root on all four lanes, stage 6 multiplies by the gain, stage 7 clamps in
// mixing mode and is the output register. A new word can enter every cycle
// unless a stall on spd has filled the pipeline, so throughput is one word
// per cycle, set by the one-word-per-stage pipeline.
//
// Each stage moves on when it is empty or the stage after it moves on, so a
// stall on spd fills empty stages first and backs up into cmd.ready only when
// all seven stages hold words. Reset empties the pipeline and loads the
// register defaults (threshold 277, gain 13, floor 200, ceiling 600).
`include "quad_motor_mixer_sqrt_core_macros.svh"

module quad_motor_mixer_sqrt_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [qmm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [qmm_pkg::CFG_W-1:0]     cfg_data,
	qmm_cmd_if.sink                        cmd,
	qmm_spd_if.source                      spd
);
	import qmm_pkg::*;

	logic signed [CMD_W-1:0] lift_threshold_q;
	logic [GAIN_W-1:0]       motor_gain_q;
	logic [SPD_W-1:0]        motor_floor_q;
	logic [SPD_W-1:0]        motor_ceiling_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en1, en2, en3, en4, en5, en6, en7;
	logic eq_s1, eq_s2, eq_s3, eq_s4, eq_s5, eq_s6, eq_s7;

	logic [SQ_W-1:0]  mag_s1 [LANES];
	sqrt_t            sq_s2  [LANES];
	sqrt_t            sq_s3  [LANES];
	sqrt_t            sq_s4  [LANES];
	sqrt_t            sq_s5  [LANES];
	logic [SPD_W-1:0] prod_s6 [LANES];
	logic [SPD_W-1:0] spd_s7 [LANES];

	logic [CMD_W-1:0] term  [LANES];
	logic [CMD_W-1:0] pitch2, roll2;
	logic             eq_d;
	sqrt_t            sq_d2 [LANES];
	sqrt_t            sq_d3 [LANES];
	sqrt_t            sq_d4 [LANES];
	sqrt_t            sq_d5 [LANES];
	logic [SPD_W-1:0] prod_d [LANES];
	logic [SPD_W-1:0] clamp_d [LANES];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lift_threshold_q <= RST_LIFT_THRESHOLD;
			motor_gain_q     <= RST_MOTOR_GAIN;
			motor_floor_q    <= RST_MOTOR_FLOOR;
			motor_ceiling_q  <= RST_MOTOR_CEILING;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LIFT_THRESHOLD: lift_threshold_q <= cfg_data;
				REG_MOTOR_GAIN:     motor_gain_q     <= cfg_data[GAIN_W-1:0];
				REG_MOTOR_FLOOR:    motor_floor_q    <= cfg_data[SPD_W-1:0];
				REG_MOTOR_CEILING:  motor_ceiling_q  <= cfg_data[SPD_W-1:0];
			endcase
		end
	end

	// Stage enables: a stage loads when it is empty or its word moves on.
	assign en7 = !v_s7 || spd.ready;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign cmd.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en1) v_s1 <= cmd.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	// Stage 1: mixed terms wrap to 16 bits; in equal-drive mode every lane
	// takes the lift magnitude instead.
	always_comb begin
		pitch2  = {cmd.pitch_cmd[CMD_W-2:0], 1'b0};
		roll2   = {cmd.roll_cmd[CMD_W-2:0], 1'b0};
		term[0] = cmd.lift_cmd - cmd.yaw_cmd + pitch2;
		term[1] = cmd.lift_cmd + cmd.yaw_cmd - roll2;
		term[2] = cmd.lift_cmd - cmd.yaw_cmd - pitch2;
		term[3] = cmd.lift_cmd + cmd.yaw_cmd + roll2;
		eq_d    = cmd.lift_cmd < lift_threshold_q;
	end

	// Stages 2 to 5: two square root steps each.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			sq_d2[l] = sqrt_step(sqrt_step('{rem: mag_s1[l], root: '0}, SQRT_BIT[0]),
				SQRT_BIT[1]);
			sq_d3[l] = sqrt_step(sqrt_step(sq_s2[l], SQRT_BIT[2]), SQRT_BIT[3]);
			sq_d4[l] = sqrt_step(sqrt_step(sq_s3[l], SQRT_BIT[4]), SQRT_BIT[5]);
			sq_d5[l] = sqrt_step(sqrt_step(sq_s4[l], SQRT_BIT[6]), SQRT_BIT[7]);
		end
	end

	// Stage 6 product fits 14 bits: root is at most 181, gain at most 63.
	// In mixing mode, stage 7 raises to the floor first and then limits to the ceiling.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			prod_d[l] = {{(SPD_W-ROOT_W){1'b0}}, sq_s5[l].root[ROOT_W-1:0]}
				* {{(SPD_W-GAIN_W){1'b0}}, motor_gain_q};
			clamp_d[l] = prod_s6[l];
			if (!eq_s6) begin
				if (clamp_d[l] < motor_floor_q) clamp_d[l] = motor_floor_q;
				if (clamp_d[l] > motor_ceiling_q) clamp_d[l] = motor_ceiling_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			eq_s1 <= eq_d;
			for (int l = 0; l < LANES; l++) begin
				mag_s1[l] <= eq_d ? mag16(cmd.lift_cmd) : mag16(term[l]);
			end
		end
		if (en2) begin
			eq_s2 <= eq_s1;
			sq_s2 <= sq_d2;
		end
		if (en3) begin
			eq_s3 <= eq_s2;
			sq_s3 <= sq_d3;
		end
		if (en4) begin
			eq_s4 <= eq_s3;
			sq_s4 <= sq_d4;
		end
		if (en5) begin
			eq_s5 <= eq_s4;
			sq_s5 <= sq_d5;
		end
		if (en6) begin
			eq_s6   <= eq_s5;
			prod_s6 <= prod_d;
		end
		if (en7) begin
			eq_s7  <= eq_s6;
			spd_s7 <= clamp_d;
		end
	end

	assign spd.valid       = v_s7;
	assign spd.motor_front = spd_s7[0];
	assign spd.motor_right = spd_s7[1];
	assign spd.motor_back  = spd_s7[2];
	assign spd.motor_left  = spd_s7[3];

	`QMM_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, cmd.valid && cmd.ready, v_s1)
	`QMM_ASSERT_SAME(a_root_range, clk, arst_n, v_s5,
		sq_s5[0].root <= ROOT_MAX && sq_s5[1].root <= ROOT_MAX &&
		sq_s5[2].root <= ROOT_MAX && sq_s5[3].root <= ROOT_MAX)
	`QMM_ASSERT_SAME(a_equal_drive, clk, arst_n, spd.valid && eq_s7,
		spd.motor_front == spd.motor_right && spd.motor_front == spd.motor_back &&
		spd.motor_front == spd.motor_left)
	`QMM_ASSERT_SAME(a_mix_ceiling, clk, arst_n, spd.valid && !eq_s7,
		spd.motor_front <= motor_ceiling_q && spd.motor_right <= motor_ceiling_q &&
		spd.motor_back <= motor_ceiling_q && spd.motor_left <= motor_ceiling_q)

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench of the quadcopter motor mixer: directed, config and random traffic.
module tb_top;
	import qmm_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int PIPE_DEPTH  = 7;

	typedef struct packed {
		logic signed [CMD_W-1:0] lift;
		logic signed [CMD_W-1:0] roll;
		logic signed [CMD_W-1:0] pitch;
		logic signed [CMD_W-1:0] yaw;
	} motor_cmd_t;

	typedef struct packed {
		logic [SPD_W-1:0] front;
		logic [SPD_W-1:0] right;
		logic [SPD_W-1:0] back;
		logic [SPD_W-1:0] left;
	} motor_spd_t;

	typedef struct packed {
		logic signed [CMD_W-1:0] threshold;
		logic [GAIN_W-1:0]       gain;
		logic [SPD_W-1:0]        lo_spd;
		logic [SPD_W-1:0]        hi_spd;
	} mixer_cfg_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	qmm_cmd_if cmd_ch();
	qmm_spd_if spd_ch();

	quad_motor_mixer_sqrt_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_ch),
		.spd       (spd_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	mixer_cfg_t mix_cfg;
	motor_spd_t speeds_due[$];
	int         miscompares = 0;
	int         words_seen = 0;
	int         idle_cycles = 0;
	int         hold_len = 0;
	bit         src_gaps_on = 1'b0;
	bit         sink_stalls_on = 1'b0;

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int unsigned cmd_magnitude(logic [CMD_W-1:0] v);
		if (v[CMD_W-1]) return 32'd65536 - {16'd0, v};
		return {16'd0, v};
	endfunction

	// Largest r with r*r <= m, built one bit at a time from the top.
	function automatic int unsigned floor_root(int unsigned m);
		int unsigned r;
		int unsigned cand;
		r = 0;
		for (int b = 7; b >= 0; b--) begin
			cand = r | (32'd1 << b);
			if (cand * cand <= m) r = cand;
		end
		return r;
	endfunction

	function automatic logic [SPD_W-1:0] clamped_speed(logic [CMD_W-1:0] term);
		int unsigned s;
		s = floor_root(cmd_magnitude(term)) * mix_cfg.gain;
		if (s < mix_cfg.lo_spd) s = mix_cfg.lo_spd;
		if (s > mix_cfg.hi_spd) s = mix_cfg.hi_spd;
		return s[SPD_W-1:0];
	endfunction

	function automatic motor_spd_t mix_motors(motor_cmd_t c);
		logic [CMD_W-1:0] l, r, p, y;
		int unsigned      s;
		motor_spd_t       w;
		l = c.lift;
		r = c.roll;
		p = c.pitch;
		y = c.yaw;
		if (c.lift < mix_cfg.threshold) begin
			s = floor_root(cmd_magnitude(l)) * mix_cfg.gain;
			w.front = s[SPD_W-1:0];
			w.right = s[SPD_W-1:0];
			w.back  = s[SPD_W-1:0];
			w.left  = s[SPD_W-1:0];
		end else begin
			// Each term wraps to 16 bits before its magnitude is taken.
			w.front = clamped_speed(l - y + (p << 1));
			w.right = clamped_speed(l + y - (r << 1));
			w.back  = clamped_speed(l - y - (p << 1));
			w.left  = clamped_speed(l + y + (r << 1));
		end
		return w;
	endfunction

	function automatic motor_cmd_t make_cmd(int l, int r, int p, int y);
		motor_cmd_t c;
		c.lift  = l[CMD_W-1:0];
		c.roll  = r[CMD_W-1:0];
		c.pitch = p[CMD_W-1:0];
		c.yaw   = y[CMD_W-1:0];
		return c;
	endfunction

	function automatic logic [CMD_W-1:0] edge_value();
		case ($urandom_range(0, 6))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			3: return 16'h0000;
			4: return 16'h0001;
			5: return 16'h4000;
			default: return 16'hC000;
		endcase
	endfunction

	function automatic motor_cmd_t rand_cmd();
		int         r;
		motor_cmd_t c;
		r = $urandom_range(0, 99);
		c.lift  = 16'($urandom);
		c.roll  = 16'($urandom);
		c.pitch = 16'($urandom);
		c.yaw   = 16'($urandom);
		if (r < 40) begin
			// Full-range fields as drawn.
		end else if (r < 60) begin
			// Lift close to the threshold, small attitude corrections.
			c.lift  = mix_cfg.threshold + 16'($urandom_range(0, 16)) - 16'd8;
			c.roll  = 16'($urandom_range(0, 600)) - 16'd300;
			c.pitch = 16'($urandom_range(0, 600)) - 16'd300;
			c.yaw   = 16'($urandom_range(0, 600)) - 16'd300;
		end else if (r < 80) begin
			c.lift  = 16'($urandom_range(0, 32767));
			c.roll  = 16'($urandom_range(0, 4000)) - 16'd2000;
			c.pitch = 16'($urandom_range(0, 4000)) - 16'd2000;
			c.yaw   = 16'($urandom_range(0, 4000)) - 16'd2000;
		end else begin
			c.lift  = edge_value();
			c.roll  = edge_value();
			c.pitch = edge_value();
			c.yaw   = edge_value();
		end
		return c;
	endfunction

	function automatic mixer_cfg_t rand_config();
		mixer_cfg_t c;
		int         r;
		int         lo, hi;
		r = $urandom_range(0, 99);
		if (r < 30) c.threshold = 16'($urandom);
		else if (r < 60) c.threshold = 16'($urandom_range(0, 2000));
		else if (r < 80) c.threshold = 16'($urandom_range(0, 400)) - 16'd200;
		else c.threshold = edge_value();
		c.gain = 6'($urandom_range(0, 63));
		lo = $urandom_range(0, 3000);
		hi = lo + $urandom_range(0, 6000);
		if ($urandom_range(0, 9) == 0) hi = 16383;
		if ($urandom_range(0, 6) == 0) begin
			c.lo_spd = 14'(hi);
			c.hi_spd = 14'(lo);
		end else begin
			c.lo_spd = 14'(lo);
			c.hi_spd = 14'(hi);
		end
		return c;
	endfunction

	// Receiver: random stalls, plus the long hold-off when one is asked for.
	initial begin : speed_sink
		int n;
		forever begin
			n = sink_stalls_on ? pick_gap() : 0;
			if (hold_len > 0) begin
				spd_ch.ready <= 1'b0;
				n = hold_len;
				hold_len = 0;
				repeat (n) @(posedge clk);
			end else if (n > 0) begin
				spd_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				spd_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : speed_checker
		motor_spd_t got;
		motor_spd_t want;
		if (arst_n && spd_ch.valid && spd_ch.ready) begin
			got = '{spd_ch.motor_front, spd_ch.motor_right, spd_ch.motor_back,
				spd_ch.motor_left};
			if (speeds_due.size() == 0) begin
				miscompares++;
				if (miscompares <= 10)
					$display("speed word %0d arrived with no command pending", words_seen);
			end else begin
				want = speeds_due.pop_front();
				if (got.front !== want.front || got.right !== want.right ||
						got.back !== want.back || got.left !== want.left) begin
					miscompares++;
					if (miscompares <= 10)
						$display("speed word %0d: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
							words_seen, want.front, want.right, want.back, want.left,
							got.front, got.right, got.back, got.left);
				end
			end
			words_seen++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (spd_ch.valid && spd_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("quad_motor_mixer_sqrt_core regression: fail");
				$finish;
			end
		end
	end

	// Leaves valid high on return so the next word can follow without a bubble.
	task automatic send_cmd(input motor_cmd_t c);
		int gap;
		gap = src_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid     <= 1'b1;
		cmd_ch.lift_cmd  <= c.lift;
		cmd_ch.roll_cmd  <= c.roll;
		cmd_ch.pitch_cmd <= c.pitch;
		cmd_ch.yaw_cmd   <= c.yaw;
		do @(posedge clk); while (!cmd_ch.ready);
		speeds_due.push_back(mix_motors(c));
	endtask

	task automatic drain_pipe();
		cmd_ch.valid <= 1'b0;
		while (speeds_due.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	// With junk set, the unused upper bits of the gain, floor and ceiling writes carry random values.
	task automatic load_config(input mixer_cfg_t c, input bit junk);
		logic [CFG_W-1:0] pad;
		pad = junk ? 16'($urandom) : '0;
		write_reg(REG_LIFT_THRESHOLD, c.threshold);
		write_reg(REG_MOTOR_GAIN, {pad[CFG_W-1:GAIN_W], c.gain});
		pad = junk ? 16'($urandom) : '0;
		write_reg(REG_MOTOR_FLOOR, {pad[CFG_W-1:SPD_W], c.lo_spd});
		pad = junk ? 16'($urandom) : '0;
		write_reg(REG_MOTOR_CEILING, {pad[CFG_W-1:SPD_W], c.hi_spd});
		cfg_we <= 1'b0;
		mix_cfg = c;
	endtask

	task automatic test_equal_drive();
		send_cmd(make_cmd(-32768, 0, 0, 0));
		send_cmd(make_cmd(-1, 32767, -32768, 12345));
		send_cmd(make_cmd(0, -5, 7, -9));
		send_cmd(make_cmd(276, 1000, -1000, 500));
		drain_pipe();
	endtask

	task automatic test_mixed_terms();
		send_cmd(make_cmd(277, 0, 0, 0));
		send_cmd(make_cmd(32767, 0, 0, -1));
		send_cmd(make_cmd(16384, 0, -8192, 0));
		send_cmd(make_cmd(0 + 300, 0, -150, 0));
		send_cmd(make_cmd(1000, 32767, 0, 0));
		send_cmd(make_cmd(1000, -32768, 0, 0));
		send_cmd(make_cmd(2000, 0, 0, 32767));
		send_cmd(make_cmd(32767, 16383, -16384, -32768));
		drain_pipe();
	endtask

	// Floor above ceiling: the ceiling wins in mixing mode.
	task automatic test_floor_over_ceiling();
		load_config('{16'sd277, 6'd13, 14'd1000, 14'd100}, 1'b0);
		send_cmd(make_cmd(5000, 100, -200, 300));
		send_cmd(make_cmd(300, 0, 0, 0));
		drain_pipe();
	endtask

	task automatic test_config_extremes();
		load_config('{16'sh8000, 6'd63, 14'd0, 14'd16383}, 1'b1);
		send_cmd(make_cmd(-32768, 0, 0, 0));
		send_cmd(make_cmd(32767, 0, 0, 0));
		drain_pipe();
		load_config('{16'sh7FFF, 6'd0, 14'd16383, 14'd16383}, 1'b1);
		send_cmd(make_cmd(32767, -1, 1, 0));
		send_cmd(make_cmd(-32768, 0, 0, 0));
		drain_pipe();
		load_config('{16'sd0, 6'd63, 14'd0, 14'd0}, 1'b0);
		send_cmd(make_cmd(-1, 0, 0, 0));
		send_cmd(make_cmd(0, 0, 0, 0));
		drain_pipe();
	endtask

	// The receiver holds off long enough for every stage to fill and cmd to stall.
	task automatic test_backpressure();
		load_config(rand_config(), 1'b1);
		src_gaps_on    = 1'b0;
		sink_stalls_on = 1'b0;
		hold_len       = HOLD_CYCLES;
		repeat (40) send_cmd(rand_cmd());
		drain_pipe();
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 6; phase++) begin
			load_config(rand_config(), 1'b1);
			src_gaps_on    = (phase != 2);
			sink_stalls_on = (phase != 2) && (phase != 4);
			repeat (115) send_cmd(rand_cmd());
			drain_pipe();
		end
	endtask

	initial begin
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= '0;
		cfg_data         <= '0;
		cmd_ch.valid     <= 1'b0;
		cmd_ch.lift_cmd  <= '0;
		cmd_ch.roll_cmd  <= '0;
		cmd_ch.pitch_cmd <= '0;
		cmd_ch.yaw_cmd   <= '0;
		mix_cfg = '{RST_LIFT_THRESHOLD, RST_MOTOR_GAIN, RST_MOTOR_FLOOR, RST_MOTOR_CEILING};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sink_stalls_on = 1'b1;
		test_equal_drive();
		test_mixed_terms();
		test_floor_over_ceiling();
		test_config_extremes();
		test_backpressure();
		test_random_traffic();

		drain_pipe();
		repeat (PIPE_DEPTH + 5) @(posedge clk);
		if (miscompares == 0 && speeds_due.size() == 0)
			$display("quad_motor_mixer_sqrt_core regression: pass");
		else
			$display("quad_motor_mixer_sqrt_core regression: fail");
		$finish;
	end

endmodule
